/* hdl/trc_pkg.sv */
// trc_pkg: shared widths, constants, controller state and command types
// for the trapezoid row compactor; no dependencies
package trc_pkg;

    localparam int WIDTH_W   = 11;
    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 8;
    localparam int CROP_W    = 9;

    // widest row the datapath handles, clamped to what the coordinates hold
    localparam int MAX_WIDTH = 1024;
    localparam int EFF_TOP   = (MAX_WIDTH > 1024) ? 1024 : ((MAX_WIDTH < 4) ? 4 : MAX_WIDTH);
    localparam int WIDTH_MIN = 4;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

    // shared restoring divider
    localparam int DIV_W     = WIDTH_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // divide by three as multiply by reciprocal, exact for values up to 1025
    localparam int RECIP3       = 2731;
    localparam int RECIP3_SHIFT = 13;
    localparam int CPROD_W      = 23;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPACING,
        ST_MODULO,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic mod_start;
        logic finish;
    } trc_cmd_t;

    typedef struct packed {
        logic div_busy;
    } trc_status_t;

endpackage

/* hdl/trc_if.sv */
// trc_if: valid/ready channel interfaces for configuration, pixels in
// and compacted writes out; uses trc_pkg widths
interface trc_cfg_if;
    import trc_pkg::*;
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] width_in_use;
    modport source (output valid, output width_in_use, input ready);
    modport sink   (input valid, input width_in_use, output ready);
endinterface

interface trc_in_if;
    import trc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    modport source (output valid, output row, output column, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input row, input column, input red, input green,
                    input blue, output ready);
endinterface

interface trc_out_if;
    import trc_pkg::*;
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_column;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    modport source (output valid, output write_enable, output out_row, output out_column,
                    output out_red, output out_green, output out_blue, input ready);
    modport sink   (input valid, input write_enable, input out_row, input out_column,
                    input out_red, input out_green, input out_blue, output ready);
endinterface

/* hdl/trapezoid_row_compactor.sv */
// trapezoid_row_compactor: top level joining controller and datapath
// depends on trc_pkg, trc_if, trc_ctrl, trc_datapath
//
// Usage:
//   cfg     write channel for width_in_use (columns per row, clamped to
//           4..1024); always ready, write only while no pixel is in flight
//   pix_in  one pixel per transfer: row, column, red, green, blue; a row is
//           fed from the centre column down to 1, then centre+1 up to width-1
//   pix_out one result per pixel: write_enable with the packed column and
//           color, or write_enable low with zero column and color
// Timing: the result is registered in the finish step, after the
//   shared 11-bit divider has run twice (width / ((row+1)/2) for the spacing,
//   then column modulo spacing). A new pixel is taken only once the previous
//   one has left the finish step.
// The result sits in an output register; the next pixel is taken while it
//   waits. A stalled receiver holds the result, and a pixel that finishes
//   behind it waits in the finish step until the register frees up.
// Reset: width returns to 1024, both write pointers clear, no result valid.
module trapezoid_row_compactor (
    input  logic             clk,
    input  logic             rst_n,
    trc_cfg_if.sink          cfg,
    trc_in_if.sink           pix_in,
    trc_out_if.source        pix_out
);
    import trc_pkg::*;

    trc_cmd_t    cmd;
    trc_status_t status;

    // configuration writes are taken at once
    assign cfg.ready = 1'b1;

    trc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    trc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg.valid),
        .cfg_width    (cfg.width_in_use),
        .in_row       (pix_in.row),
        .in_column    (pix_in.column),
        .in_red       (pix_in.red),
        .in_green     (pix_in.green),
        .in_blue      (pix_in.blue),
        .write_enable (pix_out.write_enable),
        .out_row      (pix_out.out_row),
        .out_column   (pix_out.out_column),
        .out_red      (pix_out.out_red),
        .out_green    (pix_out.out_green),
        .out_blue     (pix_out.out_blue)
    );

endmodule

/* hdl/trc_div.sv */
// trc_div: restoring unsigned divider, one quotient bit per cycle
// depends on trc_pkg
module trc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [trc_pkg::DIV_W-1:0]  dividend,
    input  logic [trc_pkg::DIV_W-1:0]  divisor,
    output logic                       busy,
    output logic [trc_pkg::DIV_W-1:0]  quotient,
    output logic [trc_pkg::DIV_W-1:0]  remainder
);
    import trc_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // one restoring step
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quot_next = {quot_reg[DIV_W-2:0], fits};
            rem_next  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/trc_datapath.sv */
// trc_datapath: width register, pixel capture, thinning test, write pointers
// and result register; depends on trc_pkg and trc_div
module trc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  trc_pkg::trc_cmd_t           cmd,
    output trc_pkg::trc_status_t        status,
    input  logic                        cfg_write,
    input  logic [trc_pkg::WIDTH_W-1:0] cfg_width,
    input  logic [trc_pkg::COORD_W-1:0] in_row,
    input  logic [trc_pkg::COORD_W-1:0] in_column,
    input  logic [trc_pkg::COLOR_W-1:0] in_red,
    input  logic [trc_pkg::COLOR_W-1:0] in_green,
    input  logic [trc_pkg::COLOR_W-1:0] in_blue,
    output logic                        write_enable,
    output logic [trc_pkg::COORD_W-1:0] out_row,
    output logic [trc_pkg::COORD_W-1:0] out_column,
    output logic [trc_pkg::COLOR_W-1:0] out_red,
    output logic [trc_pkg::COLOR_W-1:0] out_green,
    output logic [trc_pkg::COLOR_W-1:0] out_blue
);
    import trc_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    logic [COORD_W-1:0] left_ptr_reg, left_ptr_next;
    logic [COORD_W-1:0] right_ptr_reg, right_ptr_next;
    logic [COORD_W-1:0] row_reg, col_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic [CROP_W-1:0]  crop_reg;
    logic               we_reg;
    logic [COORD_W-1:0] orow_reg, ocol_reg;
    logic [COLOR_W-1:0] ored_reg, ogreen_reg, oblue_reg;

    logic [WIDTH_W-1:0] w_eff;
    logic [COORD_W-1:0] half;
    logic [COORD_W-1:0] half_p1;
    logic [WIDTH_W-1:0] in_row_p1;
    logic [WIDTH_W-1:0] in_row_p2;
    logic [CPROD_W-1:0] crop_prod;
    logic [DIV_W-1:0]   div_dividend, div_divisor;
    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_quot, div_rem;
    logic [DIV_W-1:0]   spacing;
    logic               col_ok, is_left, multiple, black, survive, we;
    logic [COORD_W-1:0] left_eff, right_eff, target;
    logic [WIDTH_W-1:0] crop_w, target_w;

    // effective width, clamped to the legal range
    always_comb
    begin
        if (width_reg < WIDTH_W'(WIDTH_MIN))
            w_eff = WIDTH_W'(WIDTH_MIN);
        else if (width_reg > WIDTH_W'(EFF_TOP))
            w_eff = WIDTH_W'(EFF_TOP);
        else
            w_eff = width_reg;
    end
    assign half    = w_eff[WIDTH_W-1:1];
    assign half_p1 = half + 1'b1;

    // edge crop (row+2)/3, registered at the transfer
    assign in_row_p1 = {1'b0, in_row} + WIDTH_W'(1);
    assign in_row_p2 = {1'b0, in_row} + WIDTH_W'(2);
    assign crop_prod = CPROD_W'(in_row_p2) * CPROD_W'(RECIP3);

    // divider operands: width / ((row+1)/2), then column % spacing
    assign spacing      = (div_quot == '0) ? DIV_W'(1) : div_quot;
    assign div_start    = cmd.accept | cmd.mod_start;
    assign div_dividend = cmd.accept ? w_eff : {1'b0, col_reg};
    assign div_divisor  = cmd.accept ? {1'b0, in_row_p1[WIDTH_W-1:1]} : spacing;

    trc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign status.div_busy = div_busy;

    // thinning, pointer selection and crop decision
    always_comb
    begin
        col_ok   = (col_reg != '0) && ({1'b0, col_reg} < w_eff);
        multiple = (row_reg != '0) && (div_rem == '0);
        black    = (red_reg == '0) && (green_reg == '0) && (blue_reg == '0);
        survive  = col_ok && !multiple && !black;
        is_left  = (col_reg <= half);
        left_eff  = (col_reg == half) ? half : left_ptr_reg;
        right_eff = (col_reg == half_p1) ? half_p1 : right_ptr_reg;
        target    = is_left ? left_eff : right_eff;
        crop_w    = {{(WIDTH_W-CROP_W){1'b0}}, crop_reg};
        target_w  = {1'b0, target};
        we = survive && (row_reg != '0) && (target_w > crop_w) && (crop_w < w_eff)
             && (target_w < (w_eff - crop_w));
        left_ptr_next  = left_ptr_reg;
        right_ptr_next = right_ptr_reg;
        if (col_ok)
        begin
            left_ptr_next  = (survive && is_left) ? (left_eff - 1'b1) : left_eff;
            right_ptr_next = (survive && !is_left) ? (right_eff + 1'b1) : right_eff;
        end
    end

    // width register and write pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            left_ptr_reg  <= '0;
            right_ptr_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                width_reg <= cfg_width;
            if (cmd.finish)
            begin
                left_ptr_reg  <= left_ptr_next;
                right_ptr_reg <= right_ptr_next;
            end
        end
    end

    // pixel capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg   <= in_row;
            col_reg   <= in_column;
            red_reg   <= in_red;
            green_reg <= in_green;
            blue_reg  <= in_blue;
            crop_reg  <= crop_prod[RECIP3_SHIFT +: CROP_W];
        end
        if (cmd.finish)
        begin
            we_reg     <= we;
            orow_reg   <= row_reg;
            ocol_reg   <= we ? target : '0;
            ored_reg   <= we ? red_reg : '0;
            ogreen_reg <= we ? green_reg : '0;
            oblue_reg  <= we ? blue_reg : '0;
        end
    end

    assign write_enable = we_reg;
    assign out_row      = orow_reg;
    assign out_column   = ocol_reg;
    assign out_red      = ored_reg;
    assign out_green    = ogreen_reg;
    assign out_blue     = oblue_reg;

endmodule

/* hdl/trc_ctrl.sv */
// trc_ctrl: sequencer for accept, two divisions and result hand-off
// depends on trc_pkg
module trc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  trc_pkg::trc_status_t status,
    output trc_pkg::trc_cmd_t    cmd
);
    import trc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SPACING;
            ST_SPACING:
                if (!status.div_busy)
                    state_next = ST_MODULO;
            ST_MODULO:
                if (!status.div_busy)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.mod_start = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SPACING:
                cmd.mod_start = !status.div_busy;
            ST_MODULO:
                ;
            ST_FINISH:
                cmd.finish = out_free;
            default:
                ;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/trc_checker.sv */
// trc_checker: port-level assertions for the row compactor, bound to the
// top level; depends on trc_pkg
module trc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        write_enable,
    input logic [trc_pkg::COORD_W-1:0] out_column,
    input logic [trc_pkg::COLOR_W-1:0] out_red,
    input logic [trc_pkg::COLOR_W-1:0] out_green,
    input logic [trc_pkg::COLOR_W-1:0] out_blue
);
    import trc_pkg::*;

    // a stalled result keeps its column and write enable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(write_enable))
        else $error("stalled result changed");

    // one pixel at a time: no new transfer right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a dropped pixel shows zero column and color
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> out_column == '0 && out_red == '0
            && out_green == '0 && out_blue == '0)
        else $error("dropped pixel carries data");

    // a written column lies past the left crop of at least one column
    a_write_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> out_column > COORD_W'(1))
        else $error("write into cropped column");

endmodule

bind trapezoid_row_compactor trc_checker u_trc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pix_in.valid),
    .in_ready     (pix_in.ready),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .write_enable (pix_out.write_enable),
    .out_column   (pix_out.out_column),
    .out_red      (pix_out.out_red),
    .out_green    (pix_out.out_green),
    .out_blue     (pix_out.out_blue)
);
